// ===== src/template_brace_tag_tokenizer_assert.svh =====
// Assertion macros for the brace-tag tokenizer.
// Taken in by the top level; needs nothing else.
`ifndef TEMPLATE_BRACE_TAG_TOKENIZER_ASSERT_SVH
`define TEMPLATE_BRACE_TAG_TOKENIZER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define TBTT_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define TBTT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/tbtt_pkg.sv =====
// Types and constants for the brace-tag tokenizer.
// Used by tbtt_scan, tbtt_queue and the top level; depends on nothing.
package tbtt_pkg;

    localparam logic [2:0] MODE_TEXT        = 3'd0;
    localparam logic [2:0] MODE_AFTER_BSL   = 3'd1;
    localparam logic [2:0] MODE_AFTER_BRACE = 3'd2;
    localparam logic [2:0] MODE_UTF8        = 3'd3;
    localparam logic [2:0] MODE_TAG         = 3'd4;
    localparam logic [2:0] MODE_TAG_ESC     = 3'd5;
    localparam logic [2:0] MODE_TAG_CLOSE   = 3'd6;

    localparam logic [1:0] RK_BYTE  = 2'd0;
    localparam logic [1:0] RK_END   = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    localparam logic [1:0] TT_TEXT    = 2'd0;
    localparam logic [1:0] TT_LITERAL = 2'd1;
    localparam logic [1:0] TT_TAG     = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Most results one beat can cause
    localparam int MAX_RES = 3;

    // Result queue
    localparam int QDEPTH = 8;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] rk;
        logic [1:0] tt;
        logic [7:0] data;
        logic       last;
    } tbtt_res_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } tbtt_qstat_t;

    function automatic tbtt_res_t mk_res(logic [1:0] rk, logic [1:0] tt, logic [7:0] data);
        tbtt_res_t r;
        r.rk   = rk;
        r.tt   = tt;
        r.data = data;
        r.last = 1'b0;
        return r;
    endfunction

    // Length of a UTF-8 character from its lead byte; 1 for bad leads
    function automatic logic [2:0] seq_len(logic [7:0] c);
        logic [2:0] n;
        if ((c & 8'h80) == 8'h00)      n = 3'd1;
        else if ((c & 8'hE0) == 8'hC0) n = 3'd2;
        else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
        else if ((c & 8'hFC) == 8'hF8) n = 3'd5;
        else if ((c & 8'hFE) == 8'hFC) n = 3'd6;
        else                           n = 3'd1;
        return n;
    endfunction

endpackage

// ===== src/tbtt_scan.sv =====
// Scanner state and per-beat decode for the brace-tag tokenizer.
// Depends on tbtt_pkg; gives up to three results per accepted beat.
module tbtt_scan
    import tbtt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    acc,
    input  logic                    kind,
    input  logic [7:0]              in_byte,
    output tbtt_res_t [MAX_RES-1:0] res,
    output logic [1:0]              res_cnt
);

    logic [2:0] mode_reg, mode_next;
    logic       text_open_reg, text_open_next;
    logic       quote_reg, quote_next;
    logic       nl_swallow_reg, nl_swallow_next;
    logic       prior_nl_reg, prior_nl_next;
    logic [2:0] utf8_left_reg, utf8_left_next;
    logic [1:0] pend_tt_reg, pend_tt_next;

    tbtt_res_t [MAX_RES-1:0] r;
    logic [1:0]              cnt;
    logic [2:0]              plen;
    logic [7:0]              delim;
    logic [7:0]              c;

    assign c     = in_byte;
    assign plen  = seq_len(c);
    assign delim = (mode_reg == MODE_AFTER_BSL) ? CH_BSL : CH_LBRACE;

    always_comb
    begin
        mode_next       = mode_reg;
        text_open_next  = text_open_reg;
        quote_next      = quote_reg;
        nl_swallow_next = nl_swallow_reg;
        prior_nl_next   = prior_nl_reg;
        utf8_left_next  = utf8_left_reg;
        pend_tt_next    = pend_tt_reg;
        r               = '0;
        cnt             = 2'd0;

        if (kind == KIND_EOS)
        begin
            unique case (mode_reg) inside
                MODE_TEXT:
                begin
                    if (text_open_reg)
                    begin
                        r[0] = mk_res(RK_END, TT_TEXT, 8'h00);
                        cnt  = 2'd1;
                    end
                end
                MODE_AFTER_BSL, MODE_AFTER_BRACE:
                begin
                    r[0] = mk_res(RK_BYTE, TT_LITERAL, delim);
                    r[1] = mk_res(RK_END, TT_LITERAL, 8'h00);
                    cnt  = 2'd2;
                end
                MODE_UTF8:
                begin
                    // close with the bytes already sent
                    r[0] = mk_res(RK_END, pend_tt_reg, 8'h00);
                    cnt  = 2'd1;
                end
                default:
                begin
                    r[0] = mk_res(RK_ERROR, TT_TAG, 8'h00);
                    cnt  = 2'd1;
                end
            endcase
            mode_next       = MODE_TEXT;
            text_open_next  = 1'b0;
            quote_next      = 1'b0;
            nl_swallow_next = 1'b0;
            prior_nl_next   = 1'b1;
            utf8_left_next  = 3'd0;
            pend_tt_next    = TT_TEXT;
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_TEXT:
                begin
                    if (c == CH_BSL || c == CH_LBRACE)
                    begin
                        if (text_open_reg)
                        begin
                            r[0] = mk_res(RK_END, TT_TEXT, 8'h00);
                            cnt  = 2'd1;
                        end
                        text_open_next  = 1'b0;
                        nl_swallow_next = 1'b0;
                        if (c == CH_BSL)
                        begin
                            prior_nl_next = 1'b0;
                            mode_next     = MODE_AFTER_BSL;
                        end
                        else
                        begin
                            mode_next = MODE_AFTER_BRACE;
                        end
                    end
                    else if (nl_swallow_reg && !text_open_reg && c == CH_NEWLINE)
                    begin
                        // drop the newline straight after a tag that began a line
                        nl_swallow_next = 1'b0;
                    end
                    else
                    begin
                        nl_swallow_next = 1'b0;
                        r[0]            = mk_res(RK_BYTE, TT_TEXT, c);
                        cnt             = 2'd1;
                        text_open_next  = 1'b1;
                        prior_nl_next   = (c == CH_NEWLINE);
                    end
                end
                MODE_AFTER_BSL, MODE_AFTER_BRACE:
                begin
                    if (c == CH_LBRACE && mode_reg == MODE_AFTER_BSL)
                    begin
                        r[0]      = mk_res(RK_BYTE, TT_LITERAL, CH_LBRACE);
                        r[1]      = mk_res(RK_END, TT_LITERAL, 8'h00);
                        cnt       = 2'd2;
                        mode_next = MODE_TEXT;
                    end
                    else if (c == CH_LBRACE)
                    begin
                        quote_next = 1'b0;
                        mode_next  = MODE_TAG;
                    end
                    else
                    begin
                        // delimiter and byte form a short text token
                        r[0]          = mk_res(RK_BYTE, TT_TEXT, delim);
                        r[1]          = mk_res(RK_BYTE, TT_TEXT, c);
                        prior_nl_next = 1'b0;
                        if (plen > 3'd1)
                        begin
                            cnt            = 2'd2;
                            utf8_left_next = plen - 3'd1;
                            pend_tt_next   = TT_TEXT;
                            mode_next      = MODE_UTF8;
                        end
                        else
                        begin
                            r[2]      = mk_res(RK_END, TT_TEXT, 8'h00);
                            cnt       = 2'd3;
                            mode_next = MODE_TEXT;
                        end
                    end
                end
                MODE_UTF8:
                begin
                    r[0]           = mk_res(RK_BYTE, pend_tt_reg, c);
                    cnt            = 2'd1;
                    utf8_left_next = utf8_left_reg - 3'd1;
                    if (utf8_left_next == 3'd0)
                    begin
                        r[1]      = mk_res(RK_END, pend_tt_reg, 8'h00);
                        cnt       = 2'd2;
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_TAG:
                begin
                    if (c == CH_RBRACE && !quote_reg)
                    begin
                        mode_next = MODE_TAG_CLOSE;
                    end
                    else
                    begin
                        r[0] = mk_res(RK_BYTE, TT_TAG, c);
                        cnt  = 2'd1;
                        if (c == CH_QUOTE)
                        begin
                            quote_next = ~quote_reg;
                        end
                        else if (c == CH_BSL && quote_reg)
                        begin
                            mode_next = MODE_TAG_ESC;
                        end
                    end
                end
                MODE_TAG_ESC:
                begin
                    r[0]      = mk_res(RK_BYTE, TT_TAG, c);
                    cnt       = 2'd1;
                    mode_next = MODE_TAG;
                end
                default:
                begin
                    if (c == CH_RBRACE)
                    begin
                        r[0]            = mk_res(RK_END, TT_TAG, 8'h00);
                        cnt             = 2'd1;
                        nl_swallow_next = prior_nl_reg;
                        prior_nl_next   = 1'b0;
                        quote_next      = 1'b0;
                        mode_next       = MODE_TEXT;
                    end
                    else
                    begin
                        // lone close brace: both bytes stay in the tag
                        r[0]      = mk_res(RK_BYTE, TT_TAG, CH_RBRACE);
                        r[1]      = mk_res(RK_BYTE, TT_TAG, c);
                        cnt       = 2'd2;
                        mode_next = MODE_TAG;
                    end
                end
            endcase
        end

        case (cnt)
            2'd1:    r[0].last = 1'b1;
            2'd2:    r[1].last = 1'b1;
            2'd3:    r[2].last = 1'b1;
            default: r[0].last = 1'b0;
        endcase
    end

    assign res     = r;
    assign res_cnt = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TEXT;
            text_open_reg  <= 1'b0;
            quote_reg      <= 1'b0;
            nl_swallow_reg <= 1'b0;
            prior_nl_reg   <= 1'b1;
            utf8_left_reg  <= 3'd0;
            pend_tt_reg    <= TT_TEXT;
        end
        else if (acc)
        begin
            mode_reg       <= mode_next;
            text_open_reg  <= text_open_next;
            quote_reg      <= quote_next;
            nl_swallow_reg <= nl_swallow_next;
            prior_nl_reg   <= prior_nl_next;
            utf8_left_reg  <= utf8_left_next;
            pend_tt_reg    <= pend_tt_next;
        end
    end

endmodule

// ===== src/tbtt_queue.sv =====
// Result queue for the brace-tag tokenizer: takes up to three results a
// cycle and hands out one. Depends on tbtt_pkg.
module tbtt_queue
    import tbtt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tbtt_res_t [MAX_RES-1:0] push_res,
    input  logic [1:0]              push_cnt,
    input  logic                    pop,
    output logic                    not_empty,
    output tbtt_res_t               head,
    output tbtt_qstat_t             stat
);

    tbtt_res_t         mem [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] add_cnt;

    assign add_cnt     = push ? QCNT_W'(push_cnt) : '0;
    assign wr_ptr_next = wr_ptr_reg + QIDX_W'(add_cnt);
    assign rd_ptr_next = pop ? rd_ptr_reg + QIDX_W'(1) : rd_ptr_reg;
    assign count_next  = count_reg + add_cnt - (pop ? QCNT_W'(1) : QCNT_W'(0));

    assign not_empty  = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    // hold input unless a full burst of results still fits
    assign stat.room  = (count_reg <= QCNT_W'(QDEPTH - MAX_RES));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (push && (QCNT_W'(i) < QCNT_W'(push_cnt)))
            begin
                mem[wr_ptr_reg + QIDX_W'(i)] <= push_res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/template_brace_tag_tokenizer.sv =====
// Brace-tag template tokenizer.
// Input channel: one beat per template byte (kind 0) or end of stream
// (kind 1), handshake in_valid / in_stall. Output channel: one beat per
// result (token byte, end of token or unterminated-tag error) with its token
// type, handshake out_valid / out_stall; last marks the final result of an
// input beat. A beat that causes no result gives no output beat.
// A beat's results are registered in the result queue. Throughput: one input
// beat per cycle while beats give at most one result each and out_stall is
// low; the output side moves one result per cycle, so beats that give two
// or three results are paid for in output cycles, buffered by an 8-entry
// result queue. in_stall rises when fewer than three queue entries are free.
// Stalling the output lets the queue fill and then holds the input; no result
// is lost or repeated. Reset clears the scanner to plain text mode and empties
// the queue; an end-of-stream beat also returns the scanner to that state.
// Files: tbtt_pkg, tbtt_scan, tbtt_queue, assertion header.
module template_brace_tag_tokenizer
    import tbtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [1:0] token_type,
    output logic [7:0] out_byte,
    output logic       last
);

    `include "template_brace_tag_tokenizer_assert.svh"

    logic                    in_acc;
    logic                    out_acc;
    tbtt_res_t [MAX_RES-1:0] res;
    logic [1:0]              res_cnt;
    tbtt_res_t               head;
    tbtt_qstat_t             qstat;
    logic                    q_not_empty;

    assign in_stall = !qstat.room;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    tbtt_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (in_acc),
        .kind    (kind),
        .in_byte (in_byte),
        .res     (res),
        .res_cnt (res_cnt)
    );

    tbtt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc),
        .push_res  (res),
        .push_cnt  (res_cnt),
        .pop       (out_acc),
        .not_empty (q_not_empty),
        .head      (head),
        .stat      (qstat)
    );

    assign out_valid   = q_not_empty;
    assign result_kind = head.rk;
    assign token_type  = head.tt;
    assign out_byte    = head.data;
    assign last        = head.last;

    `TBTT_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1,
        qstat.count <= QCNT_W'(QDEPTH), "result queue overflow")
    `TBTT_ASSERT_NEXT(a_result_shown, clk, rst_n, in_acc && res_cnt != 2'd0,
        out_valid, "accepted result not offered")
    `TBTT_ASSERT_IMPLY(a_last_three, clk, rst_n, res_cnt == 2'd3,
        res[2].last && !res[1].last && !res[0].last, "last flag misplaced in three-result beat")
    `TBTT_ASSERT_IMPLY(a_last_two, clk, rst_n, res_cnt == 2'd2,
        res[1].last && !res[0].last, "last flag misplaced in two-result beat")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the brace-tag template tokenizer.
// Drives template bytes and end-of-stream beats, predicts every token result and checks
// the output beat by beat. Depends only on tbtt_pkg and the tokenizer top level.
module tb_top;
    import tbtt_pkg::*;

    localparam int ITEMS_WANTED = 470;
    localparam int MAX_WAIT     = 17;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic       is_eos;
        logic [7:0] ch;
        logic [4:0] gap;
        logic       drain;
    } template_beat_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       kind        = KIND_DATA;
    logic [7:0] in_byte     = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] result_kind;
    logic [1:0] token_type;
    logic [7:0] out_byte;
    logic       last;

    template_beat_t template_q[$];
    tbtt_res_t      token_expect_q[$];
    tbtt_res_t      beat_results[$];

    // Scanner state as the predictor sees it
    logic [2:0] sc_mode;
    logic       sc_text_open;
    logic       sc_in_quote;
    logic       sc_swallow_nl;
    logic       sc_prev_nl;
    logic [2:0] sc_utf8_left;
    logic [1:0] sc_pend_tt;

    logic tx_idle    = 1'b0;
    logic rx_idle    = 1'b0;
    logic drain_next = 1'b0;
    logic hold_done  = 1'b0;
    int   tx_wait    = 0;
    int   rx_wait    = 0;
    int   quiet      = 0;
    int   n_items;
    int   beats_taken   = 0;
    int   templates     = 0;
    int   results_seen  = 0;
    int   tags_closed   = 0;
    int   tag_errors    = 0;
    int   literals      = 0;
    int   mismatches    = 0;

    template_brace_tag_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .token_type  (token_type),
        .out_byte    (out_byte),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [2:0] utf8_span(logic [7:0] c);
        logic [2:0] span;
        casez (c)
            8'b0???????: span = 3'd1;
            8'b110?????: span = 3'd2;
            8'b1110????: span = 3'd3;
            8'b11110???: span = 3'd4;
            8'b111110??: span = 3'd5;
            8'b1111110?: span = 3'd6;
            default:     span = 3'd1;
        endcase
        return span;
    endfunction

    function automatic void clear_scan();
        sc_mode       = MODE_TEXT;
        sc_text_open  = 1'b0;
        sc_in_quote   = 1'b0;
        sc_swallow_nl = 1'b0;
        sc_prev_nl    = 1'b1;
        sc_utf8_left  = 3'd0;
        sc_pend_tt    = TT_TEXT;
    endfunction

    function automatic void queue_result(logic [1:0] rk, logic [1:0] tt, logic [7:0] b);
        tbtt_res_t r;
        r.rk   = rk;
        r.tt   = tt;
        r.data = b;
        r.last = 1'b0;
        beat_results.push_back(r);
    endfunction

    // Delimiter plus a byte that is neither an escape nor a tag opener
    function automatic void split_pair(logic [7:0] delim, logic [7:0] c);
        logic [2:0] span;
        span = utf8_span(c);
        queue_result(RK_BYTE, TT_TEXT, delim);
        queue_result(RK_BYTE, TT_TEXT, c);
        sc_prev_nl = 1'b0;
        if (span > 3'd1)
        begin
            sc_utf8_left = span - 3'd1;
            sc_pend_tt   = TT_TEXT;
            sc_mode      = MODE_UTF8;
        end
        else
        begin
            queue_result(RK_END, TT_TEXT, 8'h00);
            sc_mode = MODE_TEXT;
        end
    endfunction

    function automatic void tokenize_beat(logic eos, logic [7:0] c);
        tbtt_res_t r;
        beat_results = {};
        if (eos == KIND_EOS)
        begin
            case (sc_mode)
                MODE_TEXT:
                    if (sc_text_open)
                        queue_result(RK_END, TT_TEXT, 8'h00);
                MODE_AFTER_BSL:
                begin
                    queue_result(RK_BYTE, TT_LITERAL, CH_BSL);
                    queue_result(RK_END, TT_LITERAL, 8'h00);
                end
                MODE_AFTER_BRACE:
                begin
                    queue_result(RK_BYTE, TT_LITERAL, CH_LBRACE);
                    queue_result(RK_END, TT_LITERAL, 8'h00);
                end
                MODE_UTF8:
                    queue_result(RK_END, sc_pend_tt, 8'h00);
                default:
                    queue_result(RK_ERROR, TT_TAG, 8'h00);
            endcase
            clear_scan();
        end
        else
        begin
            case (sc_mode)
                MODE_TEXT:
                    if (c == CH_BSL || c == CH_LBRACE)
                    begin
                        if (sc_text_open)
                            queue_result(RK_END, TT_TEXT, 8'h00);
                        sc_text_open  = 1'b0;
                        sc_swallow_nl = 1'b0;
                        if (c == CH_BSL)
                        begin
                            sc_prev_nl = 1'b0;
                            sc_mode    = MODE_AFTER_BSL;
                        end
                        else
                            sc_mode = MODE_AFTER_BRACE;
                    end
                    else if (sc_swallow_nl && !sc_text_open && c == CH_NEWLINE)
                        sc_swallow_nl = 1'b0;
                    else
                    begin
                        sc_swallow_nl = 1'b0;
                        queue_result(RK_BYTE, TT_TEXT, c);
                        sc_text_open = 1'b1;
                        sc_prev_nl   = (c == CH_NEWLINE);
                    end
                MODE_AFTER_BSL:
                    if (c == CH_LBRACE)
                    begin
                        queue_result(RK_BYTE, TT_LITERAL, CH_LBRACE);
                        queue_result(RK_END, TT_LITERAL, 8'h00);
                        sc_mode = MODE_TEXT;
                    end
                    else
                        split_pair(CH_BSL, c);
                MODE_AFTER_BRACE:
                    if (c == CH_LBRACE)
                    begin
                        sc_in_quote = 1'b0;
                        sc_mode     = MODE_TAG;
                    end
                    else
                        split_pair(CH_LBRACE, c);
                MODE_UTF8:
                begin
                    queue_result(RK_BYTE, sc_pend_tt, c);
                    sc_utf8_left = sc_utf8_left - 3'd1;
                    if (sc_utf8_left == 3'd0)
                    begin
                        queue_result(RK_END, sc_pend_tt, 8'h00);
                        sc_mode = MODE_TEXT;
                    end
                end
                MODE_TAG:
                    if (c == CH_RBRACE && !sc_in_quote)
                        sc_mode = MODE_TAG_CLOSE;
                    else
                    begin
                        queue_result(RK_BYTE, TT_TAG, c);
                        if (c == CH_QUOTE)
                            sc_in_quote = !sc_in_quote;
                        else if (c == CH_BSL && sc_in_quote)
                            sc_mode = MODE_TAG_ESC;
                    end
                MODE_TAG_ESC:
                begin
                    queue_result(RK_BYTE, TT_TAG, c);
                    sc_mode = MODE_TAG;
                end
                default:
                    if (c == CH_RBRACE)
                    begin
                        queue_result(RK_END, TT_TAG, 8'h00);
                        sc_swallow_nl = sc_prev_nl;
                        sc_prev_nl    = 1'b0;
                        sc_in_quote   = 1'b0;
                        sc_mode       = MODE_TEXT;
                    end
                    else
                    begin
                        // lone close brace: keep it and the byte after, unexamined
                        queue_result(RK_BYTE, TT_TAG, CH_RBRACE);
                        queue_result(RK_BYTE, TT_TAG, c);
                        sc_mode = MODE_TAG;
                    end
            endcase
        end
        if (beat_results.size() != 0)
        begin
            r = beat_results.pop_back();
            r.last = 1'b1;
            beat_results.push_back(r);
        end
        foreach (beat_results[i])
            token_expect_q.push_back(beat_results[i]);
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_beat(logic eos, logic [7:0] c);
        template_beat_t t;
        t.is_eos = eos;
        t.ch     = c;
        t.gap    = tx_idle ? 5'($urandom_range(0, MAX_WAIT)) : 5'd0;
        t.drain  = drain_next;
        drain_next = 1'b0;
        template_q.push_back(t);
    endfunction

    function automatic void add_ch(logic [7:0] c);
        add_beat(KIND_DATA, c);
    endfunction

    function automatic void add_eos();
        add_beat(KIND_EOS, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_ch(s[i]);
    endfunction

    function automatic logic [7:0] plain_ch();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        while (c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE || c == CH_BSL)
            c = 8'($urandom_range(32, 126));
        return c;
    endfunction

    function automatic void gen_template();
        int         nseg;
        int         len;
        int         cut;
        logic       quoted;
        logic [7:0] c;
        logic [2:0] span;
        if ($urandom_range(0, 3) == 0)
            tx_idle = !tx_idle;
        if ($urandom_range(0, 7) == 0)
            drain_next = 1'b1;
        nseg = $urandom_range(2, 8);
        for (int s = 0; s < nseg; s++)
        begin
            case ($urandom_range(0, 9)) inside
                0, 1, 2:
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        case ($urandom_range(0, 7))
                            0:       add_ch(CH_NEWLINE);
                            1:       add_ch(8'($urandom_range(128, 255)));
                            default: add_ch(plain_ch());
                        endcase
                end
                3, 4, 5:
                begin
                    add_ch(CH_LBRACE);
                    add_ch(CH_LBRACE);
                    quoted = 1'b0;
                    len = $urandom_range(0, 7);
                    for (int i = 0; i < len; i++)
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                add_ch(CH_QUOTE);
                                quoted = !quoted;
                            end
                            1:
                            begin
                                add_ch(CH_BSL);
                                // escaped byte inside a string never toggles the quote
                                if (quoted)
                                    case ($urandom_range(0, 3))
                                        0:       add_ch(CH_QUOTE);
                                        1:       add_ch(CH_RBRACE);
                                        2:       add_ch(CH_BSL);
                                        default: add_ch(plain_ch());
                                    endcase
                            end
                            2:
                            begin
                                add_ch(CH_RBRACE);
                                add_ch(plain_ch());
                            end
                            default: add_ch(plain_ch());
                        endcase
                    if (quoted)
                        add_ch(CH_QUOTE);
                    add_ch(CH_RBRACE);
                    add_ch(CH_RBRACE);
                end
                6:
                begin
                    add_ch(CH_BSL);
                    add_ch($urandom_range(0, 1) ? CH_LBRACE : plain_ch());
                end
                7:
                begin
                    add_ch($urandom_range(0, 1) ? CH_LBRACE : CH_BSL);
                    case ($urandom_range(0, 7))
                        0:       c = plain_ch();
                        1:       c = 8'hC0 | 8'($urandom_range(0, 31));
                        2:       c = 8'hE0 | 8'($urandom_range(0, 15));
                        3:       c = 8'hF0 | 8'($urandom_range(0, 7));
                        4:       c = 8'hF8 | 8'($urandom_range(0, 3));
                        5:       c = 8'hFC | 8'($urandom_range(0, 1));
                        6:       c = 8'h80 | 8'($urandom_range(0, 63));
                        default: c = 8'hFE | 8'($urandom_range(0, 1));
                    endcase
                    add_ch(c);
                    span = utf8_span(c);
                    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span) : span;
                    for (int i = 1; i < cut; i++)
                        add_ch(8'($urandom_range(0, 255)));
                    if (cut < span)
                    begin
                        add_eos();
                        return;
                    end
                end
                8:
                    add_ch(CH_NEWLINE);
                default:
                begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        add_ch(8'($urandom_range(0, 255)));
                end
            endcase
        end
        case ($urandom_range(0, 11))
            0: add_ch(CH_LBRACE);
            1: add_ch(CH_BSL);
            2:
            begin
                add_ch(CH_LBRACE);
                add_ch(CH_LBRACE);
                add_ch(plain_ch());
            end
            default: ;
        endcase
        add_eos();
        if ($urandom_range(0, 9) == 0)
            add_eos();
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : tx_side
        template_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= KIND_DATA;
            in_byte  <= 8'h00;
            tx_wait  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tokenize_beat(kind, in_byte);
                beats_taken++;
                if (kind == KIND_EOS)
                    templates++;
            end
            if (!in_valid || !in_stall)
            begin
                if (template_q.size() != 0 && tx_wait < int'(template_q[0].gap))
                begin
                    tx_wait++;
                    in_valid <= 1'b0;
                end
                else if (template_q.size() != 0
                         && !(template_q[0].drain && token_expect_q.size() != 0))
                begin
                    nxt = template_q.pop_front();
                    kind     <= nxt.is_eos;
                    in_byte  <= nxt.ch;
                    in_valid <= 1'b1;
                    tx_wait  = 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void report_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : rx_side
        tbtt_res_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (token_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got %0d/%0d/%02h/%0d",
                             $time, result_kind, token_type, out_byte, last);
                    mismatches++;
                end
                else
                begin
                    want = token_expect_q.pop_front();
                    if (want.rk !== result_kind)
                        report_field("result_kind", want.rk, result_kind);
                    if (want.tt !== token_type)
                        report_field("token_type", want.tt, token_type);
                    if (want.data !== out_byte)
                        report_field("out_byte", want.data, out_byte);
                    if (want.last !== last)
                        report_field("last", want.last, last);
                    if (want.rk == RK_ERROR)
                        tag_errors++;
                    else if (want.rk == RK_END && want.tt == TT_TAG)
                        tags_closed++;
                    else if (want.rk == RK_END && want.tt == TT_LITERAL)
                        literals++;
                end
                rx_wait = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
                // hold off once for long enough to back the block up into its input
                if (!hold_done && results_seen == HOLD_AT)
                begin
                    rx_wait   = LONG_HOLD;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 39) == 0)
                    rx_idle = !rx_idle;
            end
            else if (rx_wait != 0)
                rx_wait--;
            out_stall <= (rx_wait != 0);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        clear_scan();

        // newline text, then a tag with a quoted close, an escaped quote and a lone close
        add_str("\n");
        add_str("{{\"}\\\"\"}x}}");
        // newline straight after the tag is dropped
        add_str("\n");
        add_str("\\{");
        // six-byte lead after a brace, cut short by end of stream
        add_ch(CH_LBRACE);
        add_ch(8'hFC);
        add_ch(CH_LBRACE);
        add_ch(8'hFF);
        add_eos();
        add_ch(CH_BSL);
        add_eos();
        add_str("{{");
        add_eos();
        add_eos();
        add_ch(8'h00);
        add_ch(CH_LBRACE);
        add_eos();

        drain_next = 1'b1;
        while (template_q.size() < ITEMS_WANTED)
            gen_template();
        n_items = template_q.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_taken != n_items)
            @(posedge clk);
        while (token_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d beats over %0d templates, %0d results checked",
                 beats_taken, templates, results_seen);
        $display("summary: %0d tags closed, %0d unterminated tags, %0d literal tokens",
                 tags_closed, tag_errors, literals);
        if (mismatches == 0 && token_expect_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
